>>> sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros for the signed integer to decimal ASCII block.
// Used by the RTL files that check their own logic; no dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTH

`define SIDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SIDA_ASSERT(lbl, clk, rstn, prop, msg)

`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> sv/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies.
`default_nettype none

package sida_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIGIT_IDX_W = 4;
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned NUM_STAGES = 4;
    localparam int unsigned STEPS_PER_STAGE = VALUE_W / NUM_STAGES;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic               neg;
        t_bcd               bcd;
        logic [VALUE_W-1:0] bin;
    } t_work;

endpackage

`default_nettype wire

>>> sv/sida_dabble_stage.sv
// One registered stage of the binary to BCD converter (shift-and-add-3).
// Depends on sida_pkg.
`default_nettype none

module sida_dabble_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sida_pkg::t_work i_in_work,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output sida_pkg::t_work     o_out_work
);
    import sida_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    always_comb begin
        t_bcd               v_bcd;
        logic [VALUE_W-1:0] v_bin;
        v_bcd = i_in_work.bcd;
        v_bin = i_in_work.bin;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (v_bcd[d] >= 4'd5) begin
                    v_bcd[d] = v_bcd[d] + 4'd3;
                end
            end
            {v_bcd, v_bin} = {v_bcd, v_bin} << 1;
        end
        n_work.neg = i_in_work.neg;
        n_work.bcd = v_bcd;
        n_work.bin = v_bin;
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_work <= n_work;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_work  = r_work;

endmodule

`default_nettype wire

>>> sv/sida_serialiser.sv
// Character serialiser: sends the sign and significant digits one per transfer.
// Depends on sida_pkg and the assertion macro header.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_serialiser (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire sida_pkg::t_work          i_in_work,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);
    import sida_pkg::*;

    logic                   r_busy, n_busy;
    logic                   r_sign, n_sign;
    logic [DIGIT_IDX_W-1:0] r_idx,  n_idx;
    t_bcd                   r_bcd,  n_bcd;
    logic [DIGIT_IDX_W-1:0] w_msd;

    // index of the most significant non-zero digit, 0 for zero
    always_comb begin
        w_msd = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_in_work.bcd[d] != 4'd0) begin
                w_msd = DIGIT_IDX_W'(d);
            end
        end
    end

    assign o_valid     = r_busy;
    assign o_last_char = !r_sign && (r_idx == '0);
    assign o_char_code = r_sign ? CH_MINUS : (CH_ZERO + {2'b00, r_bcd[r_idx]});
    assign o_in_ready  = !r_busy || (i_ready && o_last_char);

    always_comb begin
        n_busy = r_busy;
        n_sign = r_sign;
        n_idx  = r_idx;
        n_bcd  = r_bcd;
        if (r_busy && i_ready) begin
            if (r_sign) begin
                n_sign = 1'b0;
            end else if (r_idx == '0) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx - 1'b1;
            end
        end
        if (i_in_valid && o_in_ready) begin
            n_busy = 1'b1;
            n_sign = i_in_work.neg;
            n_idx  = w_msd;
            n_bcd  = i_in_work.bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_sign <= n_sign;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    `SIDA_ASSERT(a_sign_not_last, i_clk, i_rst_n, !(o_valid && o_last_char && o_char_code == CH_MINUS), "minus sign flagged as last")
    `SIDA_ASSERT_NEXT(a_text_continues, i_clk, i_rst_n, o_valid && i_ready && !o_last_char, o_valid, "text ended without last flag")
    `SIDA_ASSERT(a_no_early_load, i_clk, i_rst_n, !(o_valid && !o_last_char && o_in_ready), "next number taken mid text")
    `SIDA_ASSERT(a_char_range, i_clk, i_rst_n, !o_valid || o_char_code == CH_MINUS || (o_char_code >= CH_ZERO && o_char_code <= CH_ZERO + 6'd9), "character out of range")

endmodule

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each number accepted on the
// input channel leaves as its characters, most significant first, one per
// output transfer: a minus sign for negative values, then the digits without
// leading zeros ('0' alone for zero); o_last_char marks the final character.
// The most negative value gives "-2147483648". A number takes one output
// transfer per character (digit count plus one for a sign), as set by the
// character serialiser on the output channel; an input transfer can follow in
// every cycle until the pipeline fills. From input transfer to first character
// a number passes one input register, four binary to BCD stages of eight
// shift steps each, and the serialiser register.
// Depends on sida_pkg, sida_dabble_stage and sida_serialiser.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [31:0]             i_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [5:0]                          o_char_code,
    output logic                                o_last_char
);
    import sida_pkg::*;

    logic  r_in_valid;
    t_work r_in_work;
    t_work n_in_work;

    logic  w_valid [NUM_STAGES+1];
    logic  w_ready [NUM_STAGES+1];
    t_work w_work  [NUM_STAGES+1];

    // magnitude as unsigned, correct for the most negative value
    always_comb begin
        n_in_work.neg = i_value[VALUE_W-1];
        n_in_work.bcd = '0;
        n_in_work.bin = i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                           : VALUE_W'(i_value);
    end

    assign o_ready = !r_in_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_work <= n_in_work;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_work[0]  = r_in_work;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        sida_dabble_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in_valid  (w_valid[g]),
            .o_in_ready  (w_ready[g]),
            .i_in_work   (w_work[g]),
            .o_out_valid (w_valid[g+1]),
            .i_out_ready (w_ready[g+1]),
            .o_out_work  (w_work[g+1])
        );
    end

    sida_serialiser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_valid[NUM_STAGES]),
        .o_in_ready  (w_ready[NUM_STAGES]),
        .i_in_work   (w_work[NUM_STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire
